// ===== sv/pfwc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfwc_pkg
// Shared types, constants and helpers of the PLL frequency word calculator.
// ----------------------------------------------------------------------------
package pfwc_pkg;

   localparam logic [15:0] FREQ_MIN_TENTHS = 16'd350;
   localparam logic [15:0] FREQ_MAX_TENTHS = 16'd44000;
   localparam logic [18:0] VCO_LOW_MHZ     = 19'd2200;
   localparam logic [18:0] VCO_HIGH_MHZ    = 19'd4400;
   localparam logic [2:0]  DIV_EXP_MAX     = 3'd6;
   localparam logic [9:0]  MOD_FULL        = 10'd1000;
   localparam logic [23:0] MOD_FULL_WIDE   = 24'd1000;
   localparam logic [15:0] WORD1_BASE      = 16'h8001;
   localparam logic [23:0] WORD4_BASE      = 24'h8C803C;
   // floor(t / 10) == (t * RECIP10) >> 19 for every 16-bit t
   localparam logic [16:0] RECIP10         = 17'd52429;
   // floor(x / 5) == (x * RECIP5) >> 10 for every x below 1024
   localparam logic [7:0]  RECIP5          = 8'd205;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WHOLE,
      ST_SEARCH,
      ST_QUOT,
      ST_RED5,
      ST_RED2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_whole;
      logic k_adv;
      logic load_rem;
      logic q_step;
      logic red5;
      logic red2;
   } ctrl_type;

   typedef struct packed {
      logic fits;
      logic k_last;
      logic q_last;
      logic red5_ok;
      logic red2_ok;
   } status_type;

   function automatic logic [9:0] div5(input logic [9:0] x);
      logic [17:0] prod;
      prod = x * RECIP5;
      return {2'b00, prod[17:10]};
   endfunction

   function automatic logic is_mult5(input logic [9:0] x);
      logic [9:0] q;
      logic [12:0] back;
      q    = div5(x);
      back = {3'b000, q} * 13'd5;
      return back == {3'b000, x};
   endfunction

endpackage

// ===== sv/pll_frequency_word_calc_top.sv =====
// ----------------------------------------------------------------------------
// pll_frequency_word_calc_top
// Frequency request in 0.1 MHz to three fractional-N synthesizer words.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and its three words appear with rsp_valid for a single cycle, after
// which busy drops. The time is set by the divider search (one exponent per
// cycle, up to seven), the 8-step restoring quotient through one shared
// subtractor, and up to three reduction steps each by 5 and by 2. The
// receiver cannot stall: rsp_valid is a strobe and the words must be
// captured in that cycle.
module pll_frequency_word_calc_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_freq_tenths_mhz,
   output logic        rsp_valid,
   output logic [30:0] rsp_word_int_frac,
   output logic [15:0] rsp_word_modulus,
   output logic [23:0] rsp_word_divider
);
   import pfwc_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   logic [15:0] t_ff,    t_in;
   logic [12:0] whole_ff, whole_in;
   logic [2:0]  k_ff,    k_in;
   logic [23:0] rem_ff,  rem_in;
   logic [7:0]  q_ff,    q_in;
   logic [2:0]  cnt_ff,  cnt_in;
   logic [9:0]  frac_ff, frac_in;
   logic [9:0]  mod_ff,  mod_in;

   logic [15:0] t_clamp;
   logic [32:0] whole_prod;
   logic [18:0] vco;
   logic [23:0] scaled;
   logic [23:0] sub_op;
   logic [24:0] diff;
   logic        ge;
   logic [23:0] rem_step;

   pfwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   always_comb begin
      if (req_freq_tenths_mhz < FREQ_MIN_TENTHS) begin
         t_clamp = FREQ_MIN_TENTHS;
      end else if (req_freq_tenths_mhz > FREQ_MAX_TENTHS) begin
         t_clamp = FREQ_MAX_TENTHS;
      end else begin
         t_clamp = req_freq_tenths_mhz;
      end
   end

   assign whole_prod = t_ff * RECIP10;
   assign vco        = {6'd0, whole_ff} << k_ff;
   assign scaled     = {6'd0, t_ff, 2'b00} << k_ff;

   // shared subtractor: one quotient bit per cycle, MSB first
   assign sub_op   = MOD_FULL_WIDE << cnt_ff;
   assign diff     = {1'b0, rem_ff} - {1'b0, sub_op};
   assign ge       = !diff[24];
   assign rem_step = ge ? diff[23:0] : rem_ff;

   assign status.fits    = (vco >= VCO_LOW_MHZ) && (vco <= VCO_HIGH_MHZ);
   assign status.k_last  = (k_ff == DIV_EXP_MAX);
   assign status.q_last  = (cnt_ff == 3'd0);
   assign status.red5_ok = is_mult5(frac_ff) && is_mult5(mod_ff);
   assign status.red2_ok = !frac_ff[0] && !mod_ff[0];

   always_comb begin
      t_in     = t_ff;
      whole_in = whole_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      frac_in  = frac_ff;
      mod_in   = mod_ff;
      if (ctrl.load) begin
         t_in = t_clamp;
         k_in = 3'd0;
      end
      if (ctrl.calc_whole) begin
         whole_in = whole_prod[31:19];
      end
      if (ctrl.k_adv) begin
         k_in = k_ff + 3'd1;
      end
      if (ctrl.load_rem) begin
         rem_in = scaled;
         q_in   = 8'd0;
         cnt_in = 3'd7;
      end
      if (ctrl.q_step) begin
         rem_in       = rem_step;
         q_in[cnt_ff] = ge;
         cnt_in       = cnt_ff - 3'd1;
         if (status.q_last) begin
            // remainder is now below the modulus: start reduction from it
            frac_in = rem_step[9:0];
            mod_in  = MOD_FULL;
         end
      end
      if (ctrl.red5) begin
         frac_in = div5(frac_ff);
         mod_in  = div5(mod_ff);
      end
      if (ctrl.red2) begin
         frac_in = {1'b0, frac_ff[9:1]};
         mod_in  = {1'b0, mod_ff[9:1]};
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      whole_ff <= whole_in;
      k_ff     <= k_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      frac_ff  <= frac_in;
      mod_ff   <= mod_in;
   end

   assign rsp_word_int_frac = {8'd0, q_ff, 2'b00, frac_ff, 3'b000};
   assign rsp_word_modulus  = WORD1_BASE + {3'b000, mod_ff, 3'b000};
   assign rsp_word_divider  = WORD4_BASE + {1'b0, k_ff, 20'd0};

endmodule

// ===== sv/pfwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfwc_ctrl
// Sequencer: steps the shared datapath through clamp, search, divide, reduce.
// ----------------------------------------------------------------------------
module pfwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pfwc_pkg::status_type   status,
   output pfwc_pkg::ctrl_type     ctrl,
   output logic                   busy,
   output logic                   rsp_valid
);
   import pfwc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_WHOLE;
         end
         ST_WHOLE: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.fits || status.k_last) state_in = ST_QUOT;
         end
         ST_QUOT: begin
            if (status.q_last) state_in = ST_RED5;
         end
         ST_RED5: begin
            if (!status.red5_ok) state_in = ST_RED2;
         end
         ST_RED2: begin
            if (!status.red2_ok) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         ST_WHOLE: begin
            ctrl.calc_whole = 1'b1;
         end
         ST_SEARCH: begin
            ctrl.load_rem = status.fits || status.k_last;
            ctrl.k_adv    = !(status.fits || status.k_last);
         end
         ST_QUOT: begin
            ctrl.q_step = 1'b1;
         end
         ST_RED5: begin
            ctrl.red5 = status.red5_ok;
         end
         ST_RED2: begin
            ctrl.red2 = status.red2_ok;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/pfwc_checker.sv =====
// ----------------------------------------------------------------------------
// pfwc_port_checks
// Port-level checks of the frequency word calculator, bound to the top level.
// ----------------------------------------------------------------------------
module pfwc_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_freq_tenths_mhz,
   input logic        rsp_valid,
   input logic [30:0] rsp_word_int_frac,
   input logic [15:0] rsp_word_modulus,
   input logic [23:0] rsp_word_divider
);

   // a result is a single-cycle strobe
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // a result only appears while a request is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("rsp_valid without a request in flight");

   // an accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("busy not raised after an accepted request");

   // fixed control bits of the int/frac, modulus and divider words
   a_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_modulus[2:0] == 3'b001) &&
                    (rsp_word_divider[19:0] == 20'hC803C) &&
                    (rsp_word_int_frac[2:0] == 3'b000))
      else $error("fixed bits of a result word are wrong");

endmodule

bind pll_frequency_word_calc_top pfwc_port_checks u_pfwc_port_checks (.*);
